### hdl/bkst_pkg.sv
// ----------------------------------------------------------------------------
// bkst_pkg
// Shared types, widths and codes for the bounded keyed state table.
// ----------------------------------------------------------------------------
`default_nettype none

package bkst_pkg;

  localparam int ENTRIES_DEF = 256;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int STATE_W = 3;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 9;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NOTE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_IGNORED  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DONE     = 3'd4;

  localparam logic [STATE_W-1:0] STATE_UNKNOWN = 3'd0;

  // One table record as held in the slot memory
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   checksum;
    logic [KEY_W-1:0]   method;
    logic [STATE_W-1:0] state;
  } slot_t;

  // Compare flags for one record against the request key
  typedef struct packed {
    logic key_hit;
    logic cks_hit;
    logic free;
  } cmp_t;

endpackage

`default_nettype wire

### hdl/bkst_if.sv
// ----------------------------------------------------------------------------
// bkst_if
// Valid/ready channels for requests and results of the keyed state table.
// ----------------------------------------------------------------------------
`default_nettype none

interface bkst_req_if import bkst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   image_checksum;
  logic [KEY_W-1:0]   method_number;
  logic [STATE_W-1:0] new_state;

  modport source (output valid, command, image_checksum, method_number, new_state,
                  input ready);
  modport sink   (input valid, command, image_checksum, method_number, new_state,
                  output ready);
endinterface

interface bkst_rsp_if import bkst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic [STATE_W-1:0] found_state;
  logic [CNT_W-1:0]   removed_count;
  logic [CNT_W-1:0]   entries_used;

  modport source (output valid, status, found, found_state, removed_count, entries_used,
                  input ready);
  modport sink   (input valid, status, found, found_state, removed_count, entries_used,
                  output ready);
endinterface

`default_nettype wire

### hdl/bounded_keyed_state_table_unit.sv
// ----------------------------------------------------------------------------
// bounded_keyed_state_table_unit
// Table of up to ENTRIES records keyed by image checksum and method number.
// ----------------------------------------------------------------------------
// Requests arrive on req (command, key, new state) and each gives exactly one
// result on rsp. A transfer happens on a clock edge with valid and ready high.
// Note, lookup and invalidate walk every slot of the memory once through its
// single read port, one slot a cycle, with one shared key compare unit. A
// note of the unknown state and the reserved command skip the walk.
// One request is in work at a time; req.ready is high only while idle, so a
// new request is taken only once the last one has left its finish step.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; a stalled rsp holds its result and the block
// holds the next finished result until rsp.ready frees the register.
// Reset (rst, synchronous) empties the table: a clearing pass writes every
// slot invalid with req.ready low, and the entry count returns to zero.
// entries_used always reports the valid record count after the command,
// and removed_count the records dropped by an invalidate.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_keyed_state_table_unit
  import bkst_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  bkst_req_if.sink  req,
  bkst_rsp_if.source rsp
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } fsm_t;

  fsm_t state;

  // Latched request
  logic [CMD_W-1:0]   cmd;
  logic [KEY_W-1:0]   cks;
  logic [KEY_W-1:0]   meth;
  logic [STATE_W-1:0] nstate;

  // Scan bookkeeping
  logic [CW-1:0]      scan_cnt;
  logic               data_valid;
  logic [AW-1:0]      data_idx;
  logic               hit_found;
  logic [AW-1:0]      hit_idx;
  logic [STATE_W-1:0] hit_state;
  logic               free_found;
  logic [AW-1:0]      free_idx;
  logic [CW-1:0]      removed;
  logic [CW-1:0]      occ;

  // Memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic          mem_re;
  slot_t         mem_rdata;
  cmp_t          flags;

  // Output register
  logic               rsp_valid;
  logic [STAT_W-1:0]  rsp_status;
  logic               rsp_found;
  logic [STATE_W-1:0] rsp_fstate;
  logic [CNT_W-1:0]   rsp_removed;
  logic [CNT_W-1:0]   rsp_used;

  // Finish-step results
  logic               fin_fire;
  logic [STAT_W-1:0]  status_next;
  logic               found_next;
  logic [STATE_W-1:0] fstate_next;
  logic [CW-1:0]      occ_next;
  logic               note_we;
  logic [AW-1:0]      note_idx;

  logic req_fire;
  logic skip_scan;
  logic scan_issuing;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  // Unknown-state notes and the reserved command never touch the table
  assign skip_scan = ((req.command == CMD_NOTE) && (req.new_state == STATE_UNKNOWN)) ||
                     ((req.command != CMD_NOTE) && (req.command != CMD_LOOKUP) &&
                      (req.command != CMD_INVAL));

  assign scan_issuing = (state == S_SCAN) && (scan_cnt < CW'(ENTRIES));
  assign mem_re       = scan_issuing;
  assign fin_fire     = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  bkst_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_cnt[AW-1:0]),
    .rdata (mem_rdata)
  );

  bkst_cmp u_cmp (
    .slot     (mem_rdata),
    .checksum (cks),
    .method   (meth),
    .flags    (flags)
  );

  // Work out the result and the table change once the scan is complete
  always_comb begin
    status_next = STAT_DONE;
    found_next  = 1'b0;
    fstate_next = STATE_UNKNOWN;
    occ_next    = occ;
    note_we     = 1'b0;
    note_idx    = hit_idx;
    case (cmd)
      CMD_NOTE: begin
        if (nstate == STATE_UNKNOWN) begin
          status_next = STAT_IGNORED;
        end else if (hit_found) begin
          status_next = STAT_UPDATED;
          found_next  = 1'b1;
          note_we     = 1'b1;
        end else if (free_found) begin
          status_next = STAT_INSERTED;
          note_we     = 1'b1;
          note_idx    = free_idx;
          occ_next    = occ + CW'(1);
        end else begin
          status_next = STAT_DROPPED;
        end
      end
      CMD_LOOKUP: begin
        found_next  = hit_found;
        fstate_next = hit_found ? hit_state : STATE_UNKNOWN;
      end
      CMD_INVAL: begin
        occ_next = occ - removed;
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  // Single write port shared by the clearing pass, invalidate and note
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = data_idx;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_cnt[AW-1:0];
      end
      S_SCAN: begin
        mem_we = data_valid && (cmd == CMD_INVAL) && flags.cks_hit;
      end
      S_FINISH: begin
        mem_we             = fin_fire && note_we;
        mem_waddr          = note_idx;
        mem_wdata.valid    = 1'b1;
        mem_wdata.checksum = cks;
        mem_wdata.method   = meth;
        mem_wdata.state    = nstate;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      scan_cnt   <= '0;
      data_valid <= 1'b0;
      occ        <= '0;
    end else begin
      data_valid <= scan_issuing;
      case (state)
        S_CLEAR: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_cnt == CW'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            scan_cnt <= '0;
            state    <= skip_scan ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_issuing) begin
            scan_cnt <= scan_cnt + CW'(1);
          end else if (!data_valid) begin
            // last read data evaluated: the walk is complete
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin_fire) begin
            occ   <= occ_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Request latch and scan results
  always_ff @(posedge clk) begin
    data_idx <= scan_cnt[AW-1:0];
    if (req_fire) begin
      cmd        <= req.command;
      cks        <= req.image_checksum;
      meth       <= req.method_number;
      nstate     <= req.new_state;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      removed    <= '0;
    end else if ((state == S_SCAN) && data_valid) begin
      // keep the lowest matching slot and the lowest free slot
      if (flags.key_hit && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= data_idx;
        hit_state <= mem_rdata.state;
      end
      if (flags.free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= data_idx;
      end
      if ((cmd == CMD_INVAL) && flags.cks_hit) begin
        removed <= removed + CW'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      rsp_status  <= status_next;
      rsp_found   <= found_next;
      rsp_fstate  <= fstate_next;
      rsp_removed <= (cmd == CMD_INVAL) ? CNT_W'(removed) : '0;
      rsp_used    <= CNT_W'(occ_next);
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.found         = rsp_found;
  assign rsp.found_state   = rsp_fstate;
  assign rsp.removed_count = rsp_removed;
  assign rsp.entries_used  = rsp_used;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(ENTRIES))
    else $error("record count beyond table size");

  a_scan_write_inval: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we) |-> (cmd == CMD_INVAL))
    else $error("slot written during a walk that is not an invalidate");

  a_remove_bound: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && cmd == CMD_INVAL) |-> (removed <= occ))
    else $error("more records removed than held");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == S_SCAN || state == S_FINISH))
    else $error("request transfer did not start work");

endmodule

`default_nettype wire

### hdl/bkst_mem.sv
// ----------------------------------------------------------------------------
// bkst_mem
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bkst_mem
  import bkst_pkg::*;
#(
  parameter int DEPTH = ENTRIES_DEF,
  parameter int AW    = $clog2(ENTRIES_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire slot_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output slot_t              rdata
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/bkst_cmp.sv
// ----------------------------------------------------------------------------
// bkst_cmp
// Key compare unit shared by every step of the slot scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bkst_cmp
  import bkst_pkg::*;
(
  input  wire slot_t            slot,
  input  wire logic [KEY_W-1:0] checksum,
  input  wire logic [KEY_W-1:0] method,
  output cmp_t                  flags
);

  logic cks_eq;

  assign cks_eq        = (slot.checksum == checksum);
  assign flags.cks_hit = slot.valid && cks_eq;
  assign flags.key_hit = slot.valid && cks_eq && (slot.method == method);
  assign flags.free    = !slot.valid;

endmodule

`default_nettype wire
